[design/scattering_header_parser_top_assert.svh]
// Assertion macros for the scattering header parser checker.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SCATTERING_HEADER_PARSER_TOP_ASSERT_SVH
`define SCATTERING_HEADER_PARSER_TOP_ASSERT_SVH

// Check a property outside reset.
`define SHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/shp_pkg.sv]
// Types and constants for the scattering header parser.
// No dependencies; used by the core, the top level and the checker.
package shp_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EARLY    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_FLAGS    = 3'd4,
    ST_INDEX    = 3'd5,
    ST_ROUGH    = 3'd6,
    ST_RESERVED = 3'd7
  } status_t;

  localparam logic [3:0] ID_VERSION = 4'd0;
  localparam logic [3:0] ID_FLAGS   = 4'd1;
  localparam logic [3:0] ID_INDEX   = 4'd10;
  localparam logic [3:0] ID_ROUGH0  = 4'd11;
  localparam logic [3:0] ID_ROUGH1  = 4'd12;
  localparam logic [3:0] ID_DONE    = 4'd13;

  // Word indexes, counted from byte 8 in steps of four bytes.
  localparam logic [3:0] WIDX_FLAGS      = 4'd0;
  localparam logic [3:0] WIDX_LAST_COUNT = 4'd8;
  localparam logic [3:0] WIDX_INDEX      = 4'd9;
  localparam logic [3:0] WIDX_ROUGH0     = 4'd10;
  localparam logic [3:0] WIDX_ROUGH1     = 4'd11;
  localparam logic [3:0] WIDX_RESERVED0  = 4'd12;
  localparam logic [3:0] WIDX_BASE       = 4'd2;

  localparam logic [5:0] MAGIC_LEN   = 6'd7;
  localparam logic [5:0] POS_VERSION = 6'd7;
  localparam logic [5:0] POS_FLAGS   = 6'd8;
  localparam logic [1:0] SLOT_LAST   = 2'd3;

  localparam logic [7:0]  VERSION_ONE = 8'd1;
  localparam logic [31:0] FLAGS_MAX   = 32'd3;
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_INF      = 32'h7F80_0000;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [31:0] field_value;
    status_t     status;
    logic        last;
  } result_t;

  // Expected magic byte at a given position of "SCATFUN".
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h53;
      3'd1:    b = 8'h43;
      3'd2:    b = 8'h41;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h46;
      3'd5:    b = 8'h55;
      3'd6:    b = 8'h4E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Finite and not below zero; minus zero passes.
  function automatic logic rough_ok(input logic [31:0] bits);
    return (bits < FP_INF) || (bits == FP_NEG_ZERO);
  endfunction

endpackage

[design/shp_core.sv]
// Header parse state and per-byte decode for the scattering header parser.
// Depends on shp_pkg.
module shp_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_data,
  output logic             res_valid,
  output shp_pkg::result_t res
);

  logic [5:0]  pos_r, pos_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic        rough_bad_r, rough_bad_nxt;

  logic [1:0]  slot;
  logic [3:0]  widx;
  logic [31:0] word;

  assign slot = pos_r[1:0];
  assign widx = pos_r[5:2] - shp_pkg::WIDX_BASE;
  assign word = {data_byte, partial_r};

  always_comb begin
    res_valid     = 1'b0;
    res           = '0;
    res.status    = shp_pkg::ST_OK;
    pos_nxt       = pos_r;
    partial_nxt   = partial_r;
    rough_bad_nxt = rough_bad_r;

    if (pos_r < shp_pkg::MAGIC_LEN) begin
      if (end_of_data || data_byte != shp_pkg::magic_byte(pos_r[2:0])) begin
        res_valid  = 1'b1;
        res.status = shp_pkg::ST_MAGIC;
        res.last   = 1'b1;
      end else begin
        pos_nxt = pos_r + 6'd1;
      end
    end else if (end_of_data) begin
      res_valid  = 1'b1;
      res.status = shp_pkg::ST_EARLY;
      res.last   = 1'b1;
    end else if (pos_r == shp_pkg::POS_VERSION) begin
      res_valid = 1'b1;
      if (data_byte != shp_pkg::VERSION_ONE) begin
        res.status = shp_pkg::ST_VERSION;
        res.last   = 1'b1;
      end else begin
        pos_nxt         = shp_pkg::POS_FLAGS;
        res.field_id    = shp_pkg::ID_VERSION;
        res.field_value = 32'd1;
      end
    end else if (slot != shp_pkg::SLOT_LAST) begin
      // Gather the low three bytes of the word.
      partial_nxt = partial_r | ({16'd0, data_byte} << {slot, 3'b000});
      pos_nxt     = pos_r + 6'd1;
    end else begin
      partial_nxt = '0;
      pos_nxt     = pos_r + 6'd1;
      res_valid   = 1'b1;
      res.field_value = word;
      if (widx == shp_pkg::WIDX_FLAGS) begin
        res.field_id = shp_pkg::ID_FLAGS;
        if (word > shp_pkg::FLAGS_MAX) begin
          res.status = shp_pkg::ST_FLAGS;
          res.last   = 1'b1;
        end
      end else if (widx <= shp_pkg::WIDX_LAST_COUNT) begin
        res.field_id = shp_pkg::ID_FLAGS + widx;
      end else if (widx == shp_pkg::WIDX_INDEX) begin
        res.field_id = shp_pkg::ID_INDEX;
        if (word < shp_pkg::FP_ONE || word >= shp_pkg::FP_INF) begin
          res.status = shp_pkg::ST_INDEX;
          res.last   = 1'b1;
        end
      end else if (widx == shp_pkg::WIDX_ROUGH0) begin
        res.field_id  = shp_pkg::ID_ROUGH0;
        rough_bad_nxt = !shp_pkg::rough_ok(word);
      end else if (widx == shp_pkg::WIDX_ROUGH1) begin
        res.field_id = shp_pkg::ID_ROUGH1;
        if (rough_bad_r || !shp_pkg::rough_ok(word)) begin
          res.status = shp_pkg::ST_ROUGH;
          res.last   = 1'b1;
        end
      end else if (word != '0) begin
        res.status = shp_pkg::ST_RESERVED;
        res.last   = 1'b1;
      end else if (widx == shp_pkg::WIDX_RESERVED0) begin
        res_valid = 1'b0;
      end else begin
        res.last = 1'b1;
      end
    end

    // Every closing result reads as the done id with a zero value.
    if (res.last) begin
      res.field_id    = shp_pkg::ID_DONE;
      res.field_value = '0;
      pos_nxt         = '0;
      partial_nxt     = '0;
      rough_bad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      partial_r   <= '0;
      rough_bad_r <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      partial_r   <= partial_nxt;
      rough_bad_r <= rough_bad_nxt;
    end
  end

endmodule

[design/scattering_header_parser_top.sv]
// Scattering header parser, top level: byte stream in, field results out.
// Depends on shp_pkg and shp_core.
//
// Usage:
//   The input channel carries one header byte per request: in_tdata holds
//   the byte, in_tuser[0] flags end of data (byte then ignored). A 64-byte
//   header is checked against the fixed layout: magic "SCATFUN", version,
//   flags, eight counts, refraction index, two roughness values and two
//   reserved words.
//   The output channel carries a result for each completed field except the first reserved word, then a
//   closing result with out_tlast high (done, or the first error found).
//   out_tdata is the field value, out_tuser the field id and status.
//   After any closing result the parser starts again at the magic.
// Timing:
//   One byte per cycle, sustained while the skid register is empty. A
//   result is registered in the output register, or in the skid register
//   while the output stalls, once the byte that completes the field is
//   taken; the decode is a single compare-and-assemble step between the parse state and the output register.
// Reset and stall:
//   rst_n (synchronous, active low) returns the parser to the first magic
//   byte and empties the output stage. When the receiver stalls, a second
//   result is held in a skid register and in_tready drops only once that
//   register is full, so no result is lost.
module scattering_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] field_value
  output logic [6:0]  out_tuser,  // [3:0] field_id, [6:4] status
  output logic        out_tlast   // last
);

  logic             accept;
  logic             res_valid;
  shp_pkg::result_t res;

  logic             out_valid_r;
  shp_pkg::result_t out_r;
  logic             skid_valid_r;
  shp_pkg::result_t skid_r;

  // Take a byte whenever the skid register is free.
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  shp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .end_of_data (in_tuser[0]),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        // Advance the held result; no byte was taken this cycle.
        out_valid_r  <= 1'b1;
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && res_valid;
        out_r       <= res;
      end
    end else if (accept && res_valid) begin
      // Hold the new result while the output stays stalled.
      skid_valid_r <= 1'b1;
      skid_r       <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.field_value;
  assign out_tuser  = {out_r.status, out_r.field_id};
  assign out_tlast  = out_r.last;

endmodule

[design/shp_checker.sv]
// Port-level checker for the scattering header parser, bound to the top.
// Depends on shp_pkg and scattering_header_parser_top_assert.svh.
`include "scattering_header_parser_top_assert.svh"

module shp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [6:0]  out_tuser,
  input logic        out_tlast
);

  logic        out_stall;
  logic        out_close;
  logic        out_done;
  logic        out_error;
  logic [39:0] out_item;

  assign out_stall = out_tvalid && !out_tready;
  assign out_close = out_tvalid && out_tlast;
  assign out_done  = out_tvalid && (out_tuser[3:0] == shp_pkg::ID_DONE);
  assign out_error = out_tvalid && (out_tuser[6:4] != shp_pkg::ST_OK);
  assign out_item  = {out_tdata, out_tuser, out_tlast};

  `SHP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `SHP_ASSERT(a_stall_hold, out_stall |=> out_tvalid && $stable(out_item), "stalled result changed")
  `SHP_ASSERT(a_last_is_done, out_close |-> out_done && out_tdata == 32'd0, "bad closing result")
  `SHP_ASSERT(a_error_is_last, out_error |-> out_tlast, "error result without last")
  `SHP_ASSERT(a_done_is_last, out_done |-> out_tlast, "done id without last")

endmodule

bind scattering_header_parser_top shp_checker u_shp_checker (.*);
